>>> rtl/core/prtp_pkg.sv
// Shared types and constants for the pixel record text parser.
`timescale 1ns / 1ps

package prtp_pkg;

   localparam int NUMBER_WIDTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT  = 4;

   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] MARKER_RESET   = 8'h23;

   localparam int FIELD_COUNT  = 6;
   localparam int OUT_WIDTH    = 16;
   localparam int COLOR_WIDTH  = 24;
   localparam int SEEN_WIDTH   = 3;
   localparam int LINE_WIDTH   = 32;
   localparam logic [SEEN_WIDTH-1:0] SEEN_MAX = 3'd7;

   typedef enum logic [1:0] {
      KIND_DIGIT,
      KIND_EOL,
      KIND_OTHER
   } byte_kind_type;

   // One classified byte as it travels from the front to the back.
   typedef struct packed {
      byte_kind_type kind;
      logic          marker;
      logic [3:0]    digit;
   } item_type;

endpackage

>>> rtl/core/prtp_front.sv
// Front end: accepts text bytes, holds the comment marker and classifies each byte.
`timescale 1ns / 1ps

module prtp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [7:0]        req_data_byte,
   output logic              req_stall,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data,
   input  logic              queue_full,
   output logic              push,
   output prtp_pkg::item_type push_item
);
   import prtp_pkg::*;

   logic [7:0] marker_ff;
   logic [7:0] marker_in;
   logic       is_eol;
   logic       is_digit;

   always_comb begin
      marker_in = csr_wr_en ? csr_wr_data : marker_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= MARKER_RESET;
      end else begin
         marker_ff <= marker_in;
      end
   end

   assign is_eol   = (req_data_byte == CHAR_LF) || (req_data_byte == CHAR_CR);
   assign is_digit = (req_data_byte >= CHAR_ZERO) && (req_data_byte <= CHAR_NINE);

   always_comb begin
      push_item.marker = (req_data_byte == marker_ff);
      push_item.digit  = 4'(req_data_byte - CHAR_ZERO);
      priority if (is_eol) begin
         push_item.kind = KIND_EOL;
      end else if (is_digit) begin
         push_item.kind = KIND_DIGIT;
      end else begin
         push_item.kind = KIND_OTHER;
      end
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

endmodule

>>> rtl/core/prtp_queue.sv
// Short queue of classified bytes between the front end and the back end.
`timescale 1ns / 1ps

module prtp_queue #(
   parameter int DEPTH = prtp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  prtp_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output prtp_pkg::item_type pop_item
);
   import prtp_pkg::*;

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   item_type               mem [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;

   function automatic logic [PTR_WIDTH-1:0] next_ptr(input logic [PTR_WIDTH-1:0] p);
      next_ptr = (p == PTR_WIDTH'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_WIDTH'(push) - CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   assign full      = (count_ff == CNT_WIDTH'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = mem[rd_ptr_ff];

endmodule

>>> rtl/core/prtp_back.sv
// Back end: runs the line parser on classified bytes and holds the result register.
`timescale 1ns / 1ps

module prtp_back #(
   parameter int NUMBER_WIDTH = prtp_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   input  prtp_pkg::item_type                  pop_item,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [prtp_pkg::OUT_WIDTH-1:0]      rsp_column,
   output logic [prtp_pkg::OUT_WIDTH-1:0]      rsp_row,
   output logic [prtp_pkg::OUT_WIDTH-1:0]      rsp_red,
   output logic [prtp_pkg::OUT_WIDTH-1:0]      rsp_green,
   output logic [prtp_pkg::OUT_WIDTH-1:0]      rsp_blue,
   output logic [prtp_pkg::OUT_WIDTH-1:0]      rsp_alpha,
   output logic [prtp_pkg::COLOR_WIDTH-1:0]    rsp_packed_color,
   output logic [prtp_pkg::SEEN_WIDTH-1:0]     rsp_numbers_seen,
   output logic [prtp_pkg::LINE_WIDTH-1:0]     rsp_line_count
);
   import prtp_pkg::*;

   localparam logic [1:0] MODE_LINE_START = 2'd0;
   localparam logic [1:0] MODE_RECORD     = 2'd1;
   localparam logic [1:0] MODE_COMMENT    = 2'd2;

   localparam int WIDE_WIDTH = NUMBER_WIDTH + 4;
   localparam int EXT_WIDTH  = (NUMBER_WIDTH > OUT_WIDTH) ? NUMBER_WIDTH : OUT_WIDTH;
   localparam logic [NUMBER_WIDTH-1:0] NUMBER_MAX = '1;

   logic [1:0]              mode_ff, mode_in;
   logic [NUMBER_WIDTH-1:0] acc_ff, acc_in;
   logic                    inside_ff, inside_in;
   logic [SEEN_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [NUMBER_WIDTH-1:0] fields_ff [FIELD_COUNT];
   logic [NUMBER_WIDTH-1:0] fields_in [FIELD_COUNT];
   logic [LINE_WIDTH-1:0]   lines_ff, lines_in;

   logic                    advance;
   logic                    emit;
   logic                    eff_inside;
   logic [SEEN_WIDTH-1:0]   eff_cnt;
   logic [WIDE_WIDTH-1:0]   wide_sum;
   logic [NUMBER_WIDTH-1:0] digit_value;
   logic [NUMBER_WIDTH-1:0] committed [FIELD_COUNT];
   logic [SEEN_WIDTH-1:0]   committed_cnt;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_WIDTH-1:0]    out_ff [FIELD_COUNT];
   logic [COLOR_WIDTH-1:0]  color_ff;
   logic [SEEN_WIDTH-1:0]   seen_ff;
   logic [LINE_WIDTH-1:0]   line_ff;

   function automatic logic [OUT_WIDTH-1:0] to_out(input logic [NUMBER_WIDTH-1:0] v);
      logic [EXT_WIDTH-1:0] ext;
      ext    = EXT_WIDTH'(v);
      to_out = ext[OUT_WIDTH-1:0];
   endfunction

   // The result register only blocks new work while it is full and held.
   assign advance = !(rsp_valid_ff && rsp_stall);
   assign pop     = pop_valid && advance;

   // A record begun at line start sees a cleared record state.
   assign eff_inside = (mode_ff == MODE_LINE_START) ? 1'b0 : inside_ff;
   assign eff_cnt    = (mode_ff == MODE_LINE_START) ? '0 : cnt_ff;

   assign digit_value = NUMBER_WIDTH'(pop_item.digit);
   assign wide_sum    = (WIDE_WIDTH'(acc_ff) << 3) + (WIDE_WIDTH'(acc_ff) << 1)
                      + WIDE_WIDTH'(pop_item.digit);

   always_comb begin
      for (int i = 0; i < FIELD_COUNT; i++) begin
         committed[i] = (eff_inside && (eff_cnt == SEEN_WIDTH'(i))) ? acc_ff : fields_ff[i];
      end
      committed_cnt = (eff_inside && (eff_cnt != SEEN_MAX)) ? eff_cnt + 1'b1 : eff_cnt;
   end

   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      inside_in = inside_ff;
      cnt_in    = cnt_ff;
      lines_in  = lines_ff;
      emit      = 1'b0;
      for (int i = 0; i < FIELD_COUNT; i++) begin
         fields_in[i] = fields_ff[i];
      end
      if (pop) begin
         unique case (mode_ff)
            MODE_COMMENT: begin
               if (pop_item.kind == KIND_EOL) begin
                  lines_in = lines_ff + 1'b1;
                  mode_in  = MODE_LINE_START;
               end
            end
            MODE_LINE_START, MODE_RECORD: begin
               if ((mode_ff == MODE_LINE_START) && (pop_item.kind == KIND_EOL)) begin
                  mode_in = MODE_LINE_START;
               end else if ((mode_ff == MODE_LINE_START) && pop_item.marker) begin
                  mode_in = MODE_COMMENT;
               end else if (pop_item.kind == KIND_DIGIT) begin
                  mode_in   = MODE_RECORD;
                  inside_in = 1'b1;
                  cnt_in    = eff_cnt;
                  if (!eff_inside) begin
                     acc_in = digit_value;
                  end else if (wide_sum > WIDE_WIDTH'(NUMBER_MAX)) begin
                     acc_in = NUMBER_MAX;
                  end else begin
                     acc_in = wide_sum[NUMBER_WIDTH-1:0];
                  end
               end else if (pop_item.kind == KIND_EOL) begin
                  emit      = 1'b1;
                  lines_in  = lines_ff + 1'b1;
                  mode_in   = MODE_LINE_START;
                  acc_in    = '0;
                  inside_in = 1'b0;
                  cnt_in    = '0;
                  for (int i = 0; i < FIELD_COUNT; i++) begin
                     fields_in[i] = '0;
                  end
               end else begin
                  mode_in   = MODE_RECORD;
                  acc_in    = '0;
                  inside_in = 1'b0;
                  cnt_in    = committed_cnt;
                  for (int i = 0; i < FIELD_COUNT; i++) begin
                     fields_in[i] = committed[i];
                  end
               end
            end
            default: begin
               mode_in = MODE_LINE_START;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_LINE_START;
         acc_ff    <= '0;
         inside_ff <= 1'b0;
         cnt_ff    <= '0;
         lines_ff  <= '0;
         for (int i = 0; i < FIELD_COUNT; i++) begin
            fields_ff[i] <= '0;
         end
      end else begin
         mode_ff   <= mode_in;
         acc_ff    <= acc_in;
         inside_ff <= inside_in;
         cnt_ff    <= cnt_in;
         lines_ff  <= lines_in;
         for (int i = 0; i < FIELD_COUNT; i++) begin
            fields_ff[i] <= fields_in[i];
         end
      end
   end

   assign rsp_valid_in = advance ? emit : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         for (int i = 0; i < FIELD_COUNT; i++) begin
            out_ff[i] <= to_out(committed[i]);
         end
         color_ff <= {committed[2][7:0], committed[3][7:0], committed[4][7:0]};
         seen_ff  <= committed_cnt;
         line_ff  <= lines_ff + 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_column       = out_ff[0];
   assign rsp_row          = out_ff[1];
   assign rsp_red          = out_ff[2];
   assign rsp_green        = out_ff[3];
   assign rsp_blue         = out_ff[4];
   assign rsp_alpha        = out_ff[5];
   assign rsp_packed_color = color_ff;
   assign rsp_numbers_seen = seen_ff;
   assign rsp_line_count   = line_ff;

   // A new result always carries the line count that the parser has just reached.
   assert property (@(posedge clock) disable iff (reset)
      emit |=> (rsp_valid_ff && (rsp_line_count == lines_ff)))
      else $error("result line count does not match the parser line count");

   // The record state is always clear while waiting at the start of a line.
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_LINE_START) |-> (!inside_ff && (cnt_ff == '0) && (acc_ff == '0)))
      else $error("record state not clear at line start");

   // No request is consumed while a held result blocks the output register.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !pop)
      else $error("request consumed while the result register is held");

   // Comment lines count a line but never produce a result.
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_COMMENT) |-> !emit)
      else $error("result produced from a comment line");

endmodule

>>> rtl/core/pixel_record_text_parser.sv
// Top level of the pixel record text parser: front end, byte queue and back end.
`timescale 1ns / 1ps
// An accepted byte goes into the byte queue; the back end pops it and registers any result.
// Throughput: one request per cycle; the back end pops one queued byte whenever the
// result register is empty or being taken, and the front stalls only when the queue is full.
// Reset is synchronous and active high: the parser returns to line start, counters and
// fields clear, the queue empties and the comment marker returns to '#'.

module pixel_record_text_parser #(
   parameter int NUMBER_WIDTH = prtp_pkg::NUMBER_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH  = prtp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic [7:0]                       req_data_byte,
   output logic                             req_stall,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [prtp_pkg::OUT_WIDTH-1:0]   rsp_column,
   output logic [prtp_pkg::OUT_WIDTH-1:0]   rsp_row,
   output logic [prtp_pkg::OUT_WIDTH-1:0]   rsp_red,
   output logic [prtp_pkg::OUT_WIDTH-1:0]   rsp_green,
   output logic [prtp_pkg::OUT_WIDTH-1:0]   rsp_blue,
   output logic [prtp_pkg::OUT_WIDTH-1:0]   rsp_alpha,
   output logic [prtp_pkg::COLOR_WIDTH-1:0] rsp_packed_color,
   output logic [prtp_pkg::SEEN_WIDTH-1:0]  rsp_numbers_seen,
   output logic [prtp_pkg::LINE_WIDTH-1:0]  rsp_line_count,
   input  logic                             csr_wr_en,
   input  logic [7:0]                       csr_wr_data
);
   import prtp_pkg::*;

   // Handshake between the front end and the queue. The front only classifies:
   // whether a byte ends a line, is a digit, or matches the comment marker.
   logic     push;
   item_type push_item;
   logic     queue_full;

   // Handshake between the queue and the back end, which owns all line state.
   logic     pop;
   logic     pop_valid;
   item_type pop_item;

   prtp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_stall     (req_stall),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .queue_full    (queue_full),
      .push          (push),
      .push_item     (push_item)
   );

   // The queue decouples the two sides, so a held result does not stall the
   // request side until the queue has filled.
   prtp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   // The back end accumulates numbers with a shift-and-add multiply by ten,
   // saturating at the largest value of the number width, and registers each
   // finished record in its output register.
   prtp_back #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_item         (pop_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_packed_color (rsp_packed_color),
      .rsp_numbers_seen (rsp_numbers_seen),
      .rsp_line_count   (rsp_line_count)
   );

endmodule
